@@ hw/rtl/flg_pkg.sv @@
// Shared types, constants and helper functions for the stereo flanger.
// No dependencies; the other files in hw/rtl that use it refer to it by scoped names.
`timescale 1ns / 1ps

package flg_pkg;

  // Sine LFO table: quarter wave, SineN + 1 entries
  localparam int SineAw = 8;
  localparam int SineN  = 1 << SineAw;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Delay in Q8 samples = floor(num / (1000 * 2^22)); the quotient by 1000 is
  // done as a bias to make it positive, a shift by 3 and a reciprocal of 125.
  localparam logic [33:0] DivBias   = 34'd4194304000;
  localparam logic [30:0] RecipM    = 31'd1099511628;
  localparam int          RecipSh   = 37;
  localparam logic [24:0] DelayBias = 25'd4194304;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgEnable     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLfoStep    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleRate = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDepth      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMix        = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFeedback   = 3'd5;

  typedef struct packed {
    logic               enable;
    logic [23:0]        lfo_step;
    logic [17:0]        sample_rate;
    logic [15:0]        depth;
    logic [15:0]        mix;
    logic signed [15:0] feedback;
  } cfg_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;   // latch the input frame
    logic lfo;       // lfo * depth
    logic ms;        // delay in ms, Q30
    logic num;       // ms * sample_rate
    logic div;       // reciprocal multiply
    logic addr;      // first tap read
    logic rd2;       // second tap read
    logic interp;    // linear interpolation
    logic mix;       // output mix and write-back values
    logic load_out;  // load the output register
    logic commit;    // write lines, advance index and phase
    logic bypass;    // output register takes the dry frame
  } cmd_t;

  function automatic logic [14:0] sine_at(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    x = (HalfPiQ30 * longint'(k)) / SineN;
    term = x;
    sum = x;
    for (int i = 1; i <= 9; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (i)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        8: term = term / 272;
        default: term = term / 342;
      endcase
      if ((i & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ hw/rtl/flg_if.sv @@
// Frame channel interfaces: valid/ready handshake with stereo payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface flg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;
  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface flg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

@@ hw/rtl/stereo_flanger.sv @@
// Channel    | Dir | Handshake     | Payload
// in_frame   | in  | valid / ready | in_left, in_right (signed Q1.15)
// out_frame  | out | valid / ready | out_left, out_right (signed Q1.15)
// cfg        | in  | cfg_we        | cfg_index, cfg_wdata (24 bit)
//
// An effect frame reaches the output register through the controller sequence
// (LFO multiply, delay math, two delay line reads over one memory port,
// interpolation, mix); a bypassed frame skips it. The input is ready again once
// the frame is loaded into the output register, so one frame is in work at a time.
// Reset is synchronous; the delay lines need no clearing pass, a fill count
// marks unwritten entries as zero. A stalled output holds the last step until
// out_frame.ready; the next frame may be accepted while a result waits.
// Top level: wires config registers, controller and datapath.
// Depends on flg_pkg, flg_if, flg_cfg, flg_ctrl, flg_datapath.
`timescale 1ns / 1ps

module stereo_flanger #(
  parameter int DELAY_AW = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  flg_in_if.sink                        in_frame,
  flg_out_if.source                     out_frame,
  input  logic                          cfg_we,
  input  logic [flg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [flg_pkg::CfgDataW-1:0]  cfg_wdata
);

  flg_pkg::cfg_t cfg;
  flg_pkg::cmd_t cmd;

  flg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (cfg.enable),
    .in_valid  (in_frame.valid),
    .in_ready  (in_frame.ready),
    .out_valid (out_frame.valid),
    .out_ready (out_frame.ready),
    .cmd       (cmd)
  );

  flg_datapath #(.DELAY_AW(DELAY_AW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_left   (in_frame.in_left),
    .in_right  (in_frame.in_right),
    .out_left  (out_frame.out_left),
    .out_right (out_frame.out_right)
  );

endmodule

@@ hw/rtl/flg_cfg.sv @@
// Configuration register file for the flanger.
// Depends on flg_pkg.
`timescale 1ns / 1ps

module flg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [flg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [flg_pkg::CfgDataW-1:0]  cfg_wdata,
  output flg_pkg::cfg_t                 cfg
);

  flg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b1;
      cfg_r.lfo_step    <= 24'd175;
      cfg_r.sample_rate <= 18'd48000;
      cfg_r.depth       <= 16'd16384;
      cfg_r.mix         <= 16'd16384;
      cfg_r.feedback    <= 16'sd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flg_pkg::CfgEnable:     cfg_r.enable      <= cfg_wdata[0];
        flg_pkg::CfgLfoStep:    cfg_r.lfo_step    <= cfg_wdata[23:0];
        flg_pkg::CfgSampleRate: cfg_r.sample_rate <= cfg_wdata[17:0];
        flg_pkg::CfgDepth:      cfg_r.depth       <= cfg_wdata[15:0];
        flg_pkg::CfgMix:        cfg_r.mix         <= cfg_wdata[15:0];
        flg_pkg::CfgFeedback:   cfg_r.feedback    <= $signed(cfg_wdata[15:0]);
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/flg_ctrl.sv @@
// Sequencing state machine for the flanger: handshakes and datapath strobes.
// Depends on flg_pkg.
`timescale 1ns / 1ps

module flg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output flg_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_LFO    = 10'b0000000010,
    ST_MS     = 10'b0000000100,
    ST_NUM    = 10'b0000001000,
    ST_DIV    = 10'b0000010000,
    ST_ADDR   = 10'b0000100000,
    ST_RD2    = 10'b0001000000,
    ST_INTERP = 10'b0010000000,
    ST_MIX    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   bypass_r, bypass_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    bypass_nxt = bypass_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          bypass_nxt  = !enable;
          state_nxt   = enable ? ST_LFO : ST_DONE;
        end
      end
      ST_LFO:    begin cmd.lfo    = 1'b1; state_nxt = ST_MS;     end
      ST_MS:     begin cmd.ms     = 1'b1; state_nxt = ST_NUM;    end
      ST_NUM:    begin cmd.num    = 1'b1; state_nxt = ST_DIV;    end
      ST_DIV:    begin cmd.div    = 1'b1; state_nxt = ST_ADDR;   end
      ST_ADDR:   begin cmd.addr   = 1'b1; state_nxt = ST_RD2;    end
      ST_RD2:    begin cmd.rd2    = 1'b1; state_nxt = ST_INTERP; end
      ST_INTERP: begin cmd.interp = 1'b1; state_nxt = ST_MIX;    end
      ST_MIX:    begin cmd.mix    = 1'b1; state_nxt = ST_DONE;   end
      ST_DONE: begin
        // hold until the output register can take the frame
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.bypass   = bypass_r;
          cmd.commit   = !bypass_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bypass_r    <= bypass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/flg_datapath.sv @@
// Flanger datapath: LFO, delay computation, delay line memories, interpolation,
// mixing and output register. Depends on flg_pkg; driven by flg_ctrl strobes.
`timescale 1ns / 1ps

module flg_datapath #(
  parameter int DELAY_AW = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  flg_pkg::cfg_t      cfg,
  input  flg_pkg::cmd_t      cmd,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_right,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right
);

  localparam int RpW = DELAY_AW + 8;
  localparam int LineDepth = 1 << DELAY_AW;

  // LFO table
  logic [14:0] sine_rom [0:flg_pkg::SineN];
  for (genvar g = 0; g <= flg_pkg::SineN; g++) begin : g_sine
    assign sine_rom[g] = flg_pkg::sine_at(g);
  end

  // State
  logic [23:0]         phase_r;
  logic [DELAY_AW-1:0] widx_r;
  logic                full_r;

  // Pipeline registers
  logic signed [15:0] dry_l_r, dry_r_r;
  logic signed [32:0] p1_r;
  logic signed [35:0] ms_r;
  logic signed [53:0] num_r;
  logic [23:0]        quo_r;
  logic [DELAY_AW-1:0] i1_r;
  logic [7:0]         frac_r;
  logic signed [15:0] rd_l_r, rd_r_r, a_l_r, a_r_r;
  logic               rd_ok_r, a_ok_r;
  logic signed [15:0] wet_l_r, wet_r_r;
  logic signed [15:0] mo_l_r, mo_r_r, wb_l_r, wb_r_r;
  logic signed [15:0] out_l_r, out_r_r;

  logic signed [15:0] line_l [0:LineDepth-1];
  logic signed [15:0] line_r [0:LineDepth-1];

  // LFO value from the phase before its advance
  logic [1:0]              quad;
  logic [flg_pkg::SineAw-1:0] sidx;
  logic [flg_pkg::SineAw:0]   spos;
  logic signed [15:0]      sval, lfo;

  always_comb begin
    quad = phase_r[23:22];
    sidx = phase_r[21 -: flg_pkg::SineAw];
    spos = quad[0] ? (flg_pkg::SineAw+1)'(flg_pkg::SineN) - {1'b0, sidx} : {1'b0, sidx};
    sval = $signed({1'b0, sine_rom[spos]});
    lfo  = quad[1] ? -sval : sval;
  end

  // Floor division by 1000 * 2^22
  logic signed [31:0] q22;
  logic [33:0]        ubias;
  logic [29:0]        v8;
  logic [60:0]        prod;
  logic signed [24:0] delay;
  logic [33:0]        rp_full;
  logic [RpW-1:0]     rp;
  logic [DELAY_AW-1:0] rd_addr;

  always_comb begin
    q22     = num_r[53:22];
    ubias   = 34'($signed({{2{q22[31]}}, q22})) + flg_pkg::DivBias;
    v8      = ubias[32:3];
    prod    = 61'(v8) * 61'(flg_pkg::RecipM);
    delay   = $signed({1'b0, quo_r}) - $signed(flg_pkg::DelayBias);
    rp_full = 34'({widx_r, 8'd0}) - 34'($signed(delay));
    rp      = rp_full[RpW-1:0];
    rd_addr = cmd.addr ? rp[RpW-1:8] : i1_r + 1'b1;
  end

  // Interpolation and mixing
  logic signed [9:0]  w_hi, w_lo;
  logic signed [15:0] a_l, a_r, b_l, b_r;
  logic signed [26:0] acc_l, acc_r;
  logic signed [17:0] dry_gain, mix_s;
  logic signed [16:0] mix_g;
  logic signed [35:0] mo_l, mo_r;
  logic signed [33:0] wb_l, wb_r;

  always_comb begin
    w_lo  = $signed({2'b0, frac_r});
    w_hi  = 10'sd256 - w_lo;
    a_l   = a_ok_r ? a_l_r : 16'sd0;
    a_r   = a_ok_r ? a_r_r : 16'sd0;
    b_l   = rd_ok_r ? rd_l_r : 16'sd0;
    b_r   = rd_ok_r ? rd_r_r : 16'sd0;
    acc_l = 27'(a_l * w_hi) + 27'(b_l * w_lo) + 27'sd128;
    acc_r = 27'(a_r * w_hi) + 27'(b_r * w_lo) + 27'sd128;

    mix_g    = $signed({1'b0, cfg.mix});
    mix_s    = 18'(mix_g);
    dry_gain = 18'sd32768 - mix_s;
    mo_l = 36'(dry_l_r * dry_gain) + 36'(wet_l_r * mix_g) + 36'sd16384;
    mo_r = 36'(dry_r_r * dry_gain) + 36'(wet_r_r * mix_g) + 36'sd16384;
    wb_l = (34'(dry_l_r) <<< 15) + 34'(wet_l_r * cfg.feedback) + 34'sd16384;
    wb_r = (34'(dry_r_r) <<< 15) + 34'(wet_r_r * cfg.feedback) + 34'sd16384;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      widx_r  <= '0;
      full_r  <= 1'b0;
    end else if (cmd.commit) begin
      phase_r <= phase_r + cfg.lfo_step;
      widx_r  <= widx_r + 1'b1;
      if (widx_r == DELAY_AW'(LineDepth - 1)) begin
        full_r <= 1'b1;
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dry_l_r <= in_left;
      dry_r_r <= in_right;
    end
    if (cmd.lfo) p1_r <= 33'(lfo * $signed({1'b0, cfg.depth}));
    if (cmd.ms) ms_r <= (36'(p1_r) <<< 2) + 36'(p1_r) + (36'sd1 <<< 31);
    if (cmd.num) num_r <= 54'(ms_r * $signed({1'b0, cfg.sample_rate}));
    if (cmd.div) quo_r <= prod[flg_pkg::RecipSh +: 24];
    if (cmd.addr) begin
      i1_r   <= rp[RpW-1:8];
      frac_r <= rp[7:0];
    end
    if (cmd.addr || cmd.rd2) begin
      rd_l_r  <= line_l[rd_addr];
      rd_r_r  <= line_r[rd_addr];
      // entries not yet written since reset read as zero
      rd_ok_r <= full_r || (rd_addr < widx_r);
    end
    if (cmd.rd2) begin
      a_l_r  <= rd_l_r;
      a_r_r  <= rd_r_r;
      a_ok_r <= rd_ok_r;
    end
    if (cmd.interp) begin
      wet_l_r <= acc_l[23:8];
      wet_r_r <= acc_r[23:8];
    end
    if (cmd.mix) begin
      mo_l_r <= flg_pkg::sat16(40'(mo_l >>> 15));
      mo_r_r <= flg_pkg::sat16(40'(mo_r >>> 15));
      wb_l_r <= flg_pkg::sat16(40'(wb_l >>> 15));
      wb_r_r <= flg_pkg::sat16(40'(wb_r >>> 15));
    end
    if (cmd.load_out) begin
      out_l_r <= cmd.bypass ? dry_l_r : mo_l_r;
      out_r_r <= cmd.bypass ? dry_r_r : mo_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      line_l[widx_r] <= wb_l_r;
      line_r[widx_r] <= wb_r_r;
    end
  end

  assign out_left  = out_l_r;
  assign out_right = out_r_r;

endmodule

@@ hw/rtl/flg_checker.sv @@
// Port-level checks for stereo_flanger, attached by the bind at the end.
// Depends on stereo_flanger ports only.
`timescale 1ns / 1ps

module flg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_left
);

  // one frame in flight: no new transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left))
    else $error("stalled output changed");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // a result only shows up while the input side is busy finishing it
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a frame in progress");

endmodule

bind stereo_flanger flg_checker u_flg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_frame.valid),
  .in_ready  (in_frame.ready),
  .out_valid (out_frame.valid),
  .out_ready (out_frame.ready),
  .out_left  (out_frame.out_left)
);
